// ===== sv/sorted_unique_set_store_assert.svh =====
// Assertion macros for the sorted set store.
`ifndef SORTED_UNIQUE_SET_STORE_ASSERT_SVH
`define SORTED_UNIQUE_SET_STORE_ASSERT_SVH

`ifndef SYNTH
`define SUSS_ASSERT_CLK(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error("sorted set store assertion failed");
`define SUSS_ASSERT(lbl, prop) `SUSS_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define SUSS_ASSERT_CLK(lbl, clk_s, rst_s, prop)
`define SUSS_ASSERT(lbl, prop)
`endif

`endif

// ===== sv/suss_pkg.sv =====
`timescale 1ns / 1ps
package suss_pkg;

	localparam int VAL_W       = 32;
	localparam int IDX_W       = 6;
	localparam int MODE_W      = 2;
	localparam int CNT_OUT_W   = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + VAL_W + CNT_OUT_W + 1 + 1);
	localparam int IN_PAD_W    = IN_TDATA_W - (VAL_W + IDX_W);

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,
		ST_CMP,
		ST_SHIFT,
		ST_SHIFT_WR,
		ST_RD_REQ,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RA_PTR,
		RA_SPTR,
		RA_IDX
	} rsel_t;

	typedef struct packed {
		logic  load;
		logic  rd_en;
		rsel_t rd_sel;
		logic  ptr_inc;
		logic  sptr_load;
		logic  sptr_dec;
		logic  wr_shift;
		logic  wr_ins;
		logic  cnt_inc;
		logic  cnt_clr;
		logic  set_found;
		logic  set_drop;
		logic  cap_read;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              ptr_at_cnt;
		logic              rd_lt;
		logic              rd_eq;
		logic              full;
		logic              idx_ok;
		logic              sptr_at_ptr;
		logic              out_free;
	} sts_t;

endpackage

// ===== sv/suss_ram.sv =====
`timescale 1ns / 1ps
module suss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/suss_ctrl.sv =====
`timescale 1ns / 1ps
module suss_ctrl import suss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic [MODE_W-1:0] s_mode,
	output logic              s_tready,
	input  sts_t              sts,
	output cmd_t              cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					case (s_mode)
						MODE_INSERT, MODE_LOOKUP: state_nxt = ST_SRCH;
						MODE_READ:                state_nxt = ST_RD_REQ;
						MODE_CLEAR: begin
							cmd.cnt_clr = 1'b1;
							state_nxt   = ST_DONE;
						end
						default:                  state_nxt = ST_DONE;
					endcase
				end
			end
			ST_SRCH: begin
				if (sts.ptr_at_cnt) begin
					if (sts.mode == MODE_LOOKUP) begin
						state_nxt = ST_DONE;
					end else if (sts.full) begin
						cmd.set_drop = 1'b1;
						state_nxt    = ST_DONE;
					end else begin
						cmd.sptr_load = 1'b1;
						state_nxt     = ST_SHIFT;
					end
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PTR;
					state_nxt  = ST_CMP;
				end
			end
			ST_CMP: begin
				if (sts.rd_lt) begin
					cmd.ptr_inc = 1'b1;
					state_nxt   = ST_SRCH;
				end else if (sts.rd_eq) begin
					cmd.set_found = 1'b1;
					state_nxt     = ST_DONE;
				end else if (sts.mode == MODE_LOOKUP) begin
					state_nxt = ST_DONE;
				end else if (sts.full) begin
					cmd.set_drop = 1'b1;
					state_nxt    = ST_DONE;
				end else begin
					cmd.sptr_load = 1'b1;
					state_nxt     = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (sts.sptr_at_ptr) begin
					cmd.wr_ins  = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_nxt   = ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_SPTR;
					state_nxt  = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.sptr_dec = 1'b1;
				state_nxt    = ST_SHIFT;
			end
			ST_RD_REQ: begin
				if (sts.idx_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_IDX;
					state_nxt  = ST_RD_WAIT;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_RD_WAIT: begin
				cmd.cap_read = 1'b1;
				state_nxt    = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/suss_dp.sv =====
`timescale 1ns / 1ps
module suss_dp import suss_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]      s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  cmd_t                   cmd,
	output sts_t                   sts
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
	localparam int CXW  = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	logic [MODE_W-1:0]      mode_q;
	logic signed [VAL_W-1:0] value_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CW-1:0]          ptr_q;
	logic [CW-1:0]          sptr_q;
	logic [CW-1:0]          cnt_q;
	logic                   found_q;
	logic                   drop_q;
	logic                   rvalid_q;
	logic [VAL_W-1:0]       rval_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic [VAL_W-1:0]       rd_data;
	logic [AW-1:0]          raddr;
	logic [AW-1:0]          waddr;
	logic [VAL_W-1:0]       wdata;
	logic [CW-1:0]          sptr_m1;
	logic [CMPW-1:0]        idx_x;
	logic [CMPW-1:0]        cnt_x;
	logic [CXW-1:0]         cnt_o;

	assign sptr_m1 = sptr_q - CW'(1);
	assign idx_x   = CMPW'(idx_q);
	assign cnt_x   = CMPW'(cnt_q);
	assign cnt_o   = CXW'(cnt_q);

	always_comb begin
		case (cmd.rd_sel)
			RA_PTR:  raddr = ptr_q[AW-1:0];
			RA_SPTR: raddr = sptr_m1[AW-1:0];
			RA_IDX:  raddr = idx_x[AW-1:0];
			default: raddr = ptr_q[AW-1:0];
		endcase
	end

	assign waddr = cmd.wr_shift ? sptr_q[AW-1:0] : ptr_q[AW-1:0];
	assign wdata = cmd.wr_shift ? rd_data : value_q;

	suss_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_shift | cmd.wr_ins),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= s_tuser;
			value_q <= s_tdata[VAL_W-1:0];
			idx_q   <= s_tdata[VAL_W+IDX_W-1:VAL_W];
		end
		if (cmd.load) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.sptr_load) begin
			sptr_q <= cnt_q;
		end else if (cmd.sptr_dec) begin
			sptr_q <= sptr_m1;
		end
		if (cmd.load) begin
			found_q  <= 1'b0;
			drop_q   <= 1'b0;
			rvalid_q <= 1'b0;
			rval_q   <= '0;
		end else begin
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.set_drop) begin
				drop_q <= 1'b1;
			end
			if (cmd.cap_read) begin
				rvalid_q <= 1'b1;
				rval_q   <= rd_data;
			end
		end
		if (cmd.out_load) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, rvalid_q, rval_q, cnt_o[CNT_OUT_W-1:0],
				drop_q, found_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign sts.mode        = mode_q;
	assign sts.ptr_at_cnt  = (ptr_q == cnt_q);
	assign sts.rd_lt       = ($signed(rd_data) < value_q);
	assign sts.rd_eq       = ($signed(rd_data) == value_q);
	assign sts.full        = (cnt_q == CW'(DEPTH));
	assign sts.idx_ok      = (idx_x < cnt_x);
	assign sts.sptr_at_ptr = (sptr_q == ptr_q);
	assign sts.out_free    = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== sv/sorted_unique_set_store.sv =====
`timescale 1ns / 1ps
// Sorted set of distinct signed 32-bit values, up to DEPTH entries, kept ascending.
// Input stream: s_tuser carries the mode (insert, lookup, read at index, clear);
// s_tdata carries the value and the index. Each request yields exactly one
// result on the output stream: found, full_drop, count, read_value, read_valid.
// Entries live in a single RAM with one write and one registered read port;
// a state machine drives a datapath that scans and shifts through that port.
// Work per request, from the accepting edge to the loading of the result: clear
// goes straight to the result; read checks the index against the count and, when
// it is below, reads that entry; lookup and insert scan upward from entry 0 until
// an entry is not below the value or the count is reached; an insert that stores
// then shifts the entries above it up one place, top entry first, and writes the value.
// The next request is taken in the cycle after the result is loaded.
// After reset the set is empty and no RAM clearing pass is needed.
// A result waits in the output register while m_tready is low; a request that
// has finished its work then holds until the register drains.
module sorted_unique_set_store import suss_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // value[31:0], index[37:32], zeros
	input  logic [MODE_W-1:0]      s_tuser,  // mode[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // found, full_drop, count[8:2],
	                                         // read_value[40:9], read_valid[41], zeros
);

`include "sorted_unique_set_store_assert.svh"

	cmd_t cmd;
	sts_t sts;

	suss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_mode   (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	suss_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	`SUSS_ASSERT(a_drop_only_when_full, m_tvalid && m_tdata[1] |-> m_tdata[8:2] == 7'(DEPTH))
	`SUSS_ASSERT(a_found_drop_excl, m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
	`SUSS_ASSERT(a_read_no_flags, m_tvalid && m_tdata[41] |-> !m_tdata[0] && !m_tdata[1])
	`SUSS_ASSERT(a_no_write_when_idle, cmd.wr_shift || cmd.wr_ins |-> !s_tready)

endmodule
